// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the integer matrix multiply RTL.
// Bodies compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IMM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define IMM_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define IMM_ASSERT(lbl, clk, rst, prop)
`define IMM_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: hw/rtl/imm_pkg.sv
// Package for the integer matrix multiply block: sizes, codes, control structs
// and small helper functions. No dependencies.
package imm_pkg;

   localparam int MAX_DIM        = 8;
   localparam int ELEM_BITS      = 16;
   localparam int IN_ELEM_BITS   = 16;
   localparam int EFF_BITS       = (ELEM_BITS < IN_ELEM_BITS) ? ELEM_BITS : IN_ELEM_BITS;
   localparam int IDX_BITS       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W          = $clog2(MAX_DIM + 1);
   localparam int DEPTH          = MAX_DIM * MAX_DIM;
   localparam int ADDR_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FIELD_IDX_BITS = 3;
   localparam int ACC_BITS       = 32;
   localparam int REQ_TYPE_W     = 2;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 40;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 4;
   localparam int DIM_RESET      = (MAX_DIM < 8) ? MAX_DIM : 8;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_WRITE_LEFT  = 2'd0,
      REQ_WRITE_RIGHT = 2'd1,
      REQ_COMPUTE     = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ROWS_A    = 2'd0,
      CSR_INNER_DIM = 2'd1,
      CSR_COLS_B    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_STORE
   } state_type;

   typedef struct packed {
      logic                wr_left;
      logic                wr_right;
      logic                rd_en;
      logic                acc_clear;
      logic                load_out;
      logic                out_last;
      logic [IDX_BITS-1:0] row;
      logic [IDX_BITS-1:0] col;
      logic [IDX_BITS-1:0] k;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } stat_type;

   // 0 is taken as 1, anything above MAX_DIM saturates
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v);
      logic [DIM_W-1:0] d;
      if (v == '0)
         d = DIM_W'(1);
      else if (v > CSR_DATA_W'(MAX_DIM))
         d = DIM_W'(MAX_DIM);
      else
         d = DIM_W'(v);
      return d;
   endfunction

   function automatic logic is_last(input logic [IDX_BITS-1:0] idx,
                                    input logic [DIM_W-1:0] dim);
      return ((DIM_W+1)'(idx) + (DIM_W+1)'(1)) == (DIM_W+1)'(dim);
   endfunction

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_BITS-1:0] row,
                                                   input logic [IDX_BITS-1:0] col);
      return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
   endfunction

endpackage

// File: hw/rtl/integer_matrix_multiply.sv
// Integer matrix multiply: stores A (rows_a x inner_dim) and B (inner_dim x cols_b)
// element by element and streams C = A * B in row-major order, each entry wrapped
// to 32 bits. Element writes are taken back to back while idle. A compute
// transaction does one multiply-accumulate per cycle through the element RAM read,
// the multiplier and the accumulator; for each entry the drain states ST_DRAIN1
// and ST_DRAIN2 then empty that pipeline and ST_STORE loads the result register,
// waiting there while the output stalls. No new request is taken until the last
// entry is loaded. Depends on imm_pkg, imm_ctrl, imm_datapath.
module integer_matrix_multiply (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [2:0] elem_row, [5:3] elem_col, [21:6] elem_value, [23:22] zero
   input  logic [imm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] req_type
   input  logic [imm_pkg::REQ_TYPE_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] prod_value, [34:32] prod_row, [37:35] prod_col, [39:38] zero
   output logic [imm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [imm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [imm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import imm_pkg::*;

   cmd_type                   cmd;
   stat_type                  stat;
   logic [ACC_BITS-1:0]       prod_value;
   logic [FIELD_IDX_BITS-1:0] prod_row, prod_col;

   imm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .rsp_ready (rsp_tready),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .cmd       (cmd)
   );

   imm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_row   (req_tdata[2:0]),
      .req_col   (req_tdata[5:3]),
      .req_value (req_tdata[21:6]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (prod_value),
      .rsp_row   (prod_row),
      .rsp_col   (prod_col),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, prod_col, prod_row, prod_value};

endmodule

// File: hw/rtl/imm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module imm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/imm_datapath.sv
// Datapath: element stores, read/multiply/accumulate pipeline and result register.
// Depends on imm_pkg, imm_ram and assert_macros.svh.
`include "assert_macros.svh"
module imm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  imm_pkg::cmd_type                     cmd,
   output imm_pkg::stat_type                    stat,
   input  logic [imm_pkg::FIELD_IDX_BITS-1:0]   req_row,
   input  logic [imm_pkg::FIELD_IDX_BITS-1:0]   req_col,
   input  logic [imm_pkg::IN_ELEM_BITS-1:0]     req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [imm_pkg::ACC_BITS-1:0]         rsp_value,
   output logic [imm_pkg::FIELD_IDX_BITS-1:0]   rsp_row,
   output logic [imm_pkg::FIELD_IDX_BITS-1:0]   rsp_col,
   output logic                                 rsp_last
);
   import imm_pkg::*;

   logic                             in_range;
   logic [ADDR_W-1:0]                wr_addr;
   logic [ADDR_W-1:0]                left_rd_addr;
   logic [ADDR_W-1:0]                right_rd_addr;
   logic [EFF_BITS-1:0]              left_data;
   logic [EFF_BITS-1:0]              right_data;
   logic signed [2*EFF_BITS-1:0]     prod_full;
   logic [ACC_BITS-1:0]              prod_ff, prod_in;
   logic [ACC_BITS-1:0]              acc_ff, acc_in;
   logic                             v1_ff, v2_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ACC_BITS-1:0]              rsp_value_ff;
   logic [FIELD_IDX_BITS-1:0]        rsp_row_ff, rsp_col_ff;
   logic                             rsp_last_ff;

   assign in_range = ((FIELD_IDX_BITS+1)'(req_row) < (FIELD_IDX_BITS+1)'(MAX_DIM)) &&
                     ((FIELD_IDX_BITS+1)'(req_col) < (FIELD_IDX_BITS+1)'(MAX_DIM));
   assign wr_addr       = elem_addr(IDX_BITS'(req_row), IDX_BITS'(req_col));
   assign left_rd_addr  = elem_addr(cmd.row, cmd.k);
   assign right_rd_addr = elem_addr(cmd.k, cmd.col);

   imm_ram #(.WIDTH(EFF_BITS), .DEPTH(DEPTH)) u_left_store (
      .clock   (clock),
      .wr_en   (cmd.wr_left && in_range),
      .wr_addr (wr_addr),
      .wr_data (req_value[EFF_BITS-1:0]),
      .rd_en   (cmd.rd_en),
      .rd_addr (left_rd_addr),
      .rd_data (left_data)
   );

   imm_ram #(.WIDTH(EFF_BITS), .DEPTH(DEPTH)) u_right_store (
      .clock   (clock),
      .wr_en   (cmd.wr_right && in_range),
      .wr_addr (wr_addr),
      .wr_data (req_value[EFF_BITS-1:0]),
      .rd_en   (cmd.rd_en),
      .rd_addr (right_rd_addr),
      .rd_data (right_data)
   );

   // product of two sign-extended elements fits in 2*EFF_BITS <= 32 bits
   assign prod_full = $signed(left_data) * $signed(right_data);

   always_comb begin
      prod_in = prod_ff;
      if (v1_ff) begin
         prod_in = ACC_BITS'(prod_full);
      end
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + prod_ff;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         v1_ff        <= cmd.rd_en;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load_out) begin
         rsp_value_ff <= acc_ff;
         rsp_row_ff   <= FIELD_IDX_BITS'(cmd.row);
         rsp_col_ff   <= FIELD_IDX_BITS'(cmd.col);
         rsp_last_ff  <= cmd.out_last;
      end
   end

   assign stat.out_full = rsp_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_col       = rsp_col_ff;
   assign rsp_last      = rsp_last_ff;

   `IMM_ASSERT(a_v2_follows_v1, clock, reset, v2_ff |-> $past(v1_ff))
   `IMM_NEVER(a_no_load_mid_mac, clock, reset, cmd.load_out && (v1_ff || v2_ff))
   `IMM_ASSERT(a_valid_from_load, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.load_out))

endmodule

// File: hw/rtl/imm_ctrl.sv
// Controller: dimension registers, request decode and the row/column/inner
// sequencer that drives the datapath. Depends on imm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module imm_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [imm_pkg::REQ_TYPE_W-1:0]    req_kind,
   input  logic                              rsp_ready,
   input  logic                              csr_we,
   input  logic [imm_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [imm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  imm_pkg::stat_type                 stat,
   output imm_pkg::cmd_type                  cmd
);
   import imm_pkg::*;

   state_type           state_ff, state_in;
   logic [DIM_W-1:0]    rows_ff, inner_ff, cols_ff;
   logic [IDX_BITS-1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic                entry_last;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DIM_W'(DIM_RESET);
         inner_ff <= DIM_W'(DIM_RESET);
         cols_ff  <= DIM_W'(DIM_RESET);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ROWS_A:    rows_ff  <= clamp_dim(csr_wdata);
            CSR_INNER_DIM: inner_ff <= clamp_dim(csr_wdata);
            CSR_COLS_B:    cols_ff  <= clamp_dim(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         r_ff     <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         k_ff     <= k_in;
      end
   end

   assign entry_last = is_last(r_ff, rows_ff) && is_last(c_ff, cols_ff);

   always_comb begin
      state_in      = state_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      k_in          = k_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.row       = r_ff;
      cmd.col       = c_ff;
      cmd.k         = k_ff;
      cmd.out_last  = entry_last;
      unique case (state_ff)
         ST_IDLE: begin
            // ready is always high here, so valid alone marks the transaction
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_kind)
                  REQ_WRITE_LEFT:  cmd.wr_left = 1'b1;
                  REQ_WRITE_RIGHT: cmd.wr_right = 1'b1;
                  REQ_COMPUTE: begin
                     r_in     = '0;
                     c_in     = '0;
                     k_in     = '0;
                     state_in = ST_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.rd_en     = 1'b1;
            cmd.acc_clear = (k_ff == '0);
            if (is_last(k_ff, inner_ff)) begin
               k_in     = '0;
               state_in = ST_DRAIN1;
            end else begin
               k_in = k_ff + IDX_BITS'(1);
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_STORE;
         ST_STORE: begin
            if (!stat.out_full || rsp_ready) begin
               cmd.load_out = 1'b1;
               if (entry_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  if (is_last(c_ff, cols_ff)) begin
                     c_in = '0;
                     r_in = r_ff + IDX_BITS'(1);
                  end else begin
                     c_in = c_ff + IDX_BITS'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `IMM_ASSERT(a_load_when_free, clock, reset, cmd.load_out |-> (!stat.out_full || rsp_ready))
   `IMM_ASSERT(a_k_in_range, clock, reset,
               (state_ff == ST_ISSUE) |-> ((DIM_W+1)'(k_ff) < (DIM_W+1)'(inner_ff)))
   `IMM_ASSERT(a_last_ends_run, clock, reset,
               (cmd.load_out && cmd.out_last) |=> (state_ff == ST_IDLE))

endmodule
